// File: src/fdac_pkg.sv
// fdac_pkg: constants, codes and types shared by the fixed-point to decimal text core
// used by fdac_bcd_cell, fdac_bcd_chain and fixed_to_decimal_ascii_core
`default_nettype none

package fdac_pkg;

   // fixed-point format of the input value
   localparam int VALUE_W       = 32;
   localparam int FRAC_BITS_DEF = 16;

   // integer digit chain and fraction digit limits
   localparam int INT_DIGITS = 8;
   localparam int MAX_DEC    = 6;
   localparam int IDX_W      = $clog2(INT_DIGITS + 1);
   localparam int DSEL_W     = $clog2(INT_DIGITS);

   // character codes
   localparam int CHAR_W = 6;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CH_NINE  = 6'd57;
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
   localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;

   // register file
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam int IP_W       = 4;
   localparam int DP_W       = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_INT_PLACES = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_DEC_PLACES = 1'b1;
   localparam logic [IP_W-1:0] INT_PLACES_RST = 4'd0;
   localparam logic [DP_W-1:0] DEC_PLACES_RST = 3'd2;

   typedef logic [INT_DIGITS-1:0][3:0] digit_vec_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } chain_ctrl_type;

endpackage

`default_nettype wire

// File: src/fdac_bcd_cell.sv
// fdac_bcd_cell: one bcd digit of the shift-and-add-3 binary to decimal chain
// depends on fdac_pkg
`default_nettype none

module fdac_bcd_cell
   import fdac_pkg::*;
(
   input  wire logic           clock,
   input  wire chain_ctrl_type ctrl,
   input  wire logic           bit_in,
   output logic [3:0]          digit,
   output logic                carry_out
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adj;

   // add 3 before the shift so the doubled digit carries correctly
   assign adj       = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adj[3];
   assign digit     = digit_ff;

   always_comb begin
      priority if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.shift) begin
         digit_in = {adj[2:0], bit_in};
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

`default_nettype wire

// File: src/fdac_bcd_chain.sv
// fdac_bcd_chain: row of bcd cells fed one binary bit per cycle while shift is asserted, msb first
// depends on fdac_pkg and fdac_bcd_cell
`default_nettype none

module fdac_bcd_chain
   import fdac_pkg::*;
(
   input  wire logic           clock,
   input  wire chain_ctrl_type ctrl,
   input  wire logic           ser_in,
   output digit_vec_type       digits,
   output logic [IDX_W-1:0]    sig_count,
   output logic                overflow
);

   logic [INT_DIGITS:0] links;

   assign links[0] = ser_in;
   assign overflow = links[INT_DIGITS];

   for (genvar i = 0; i < INT_DIGITS; i++) begin : g_cell
      fdac_bcd_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .bit_in    (links[i]),
         .digit     (digits[i]),
         .carry_out (links[i+1])
      );
   end

   // count of significant digits: position of the highest nonzero cell
   always_comb begin
      sig_count = '0;
      for (int i = 0; i < INT_DIGITS; i++) begin
         if (digits[i] != 4'd0) begin
            sig_count = IDX_W'(i + 1);
         end
      end
   end

endmodule

`default_nettype wire

// File: src/fixed_to_decimal_ascii_core.sv
// channel | dir | ports                         | beat contents
// req     | in  | req_tvalid/tready/tdata[31:0] | value, signed fixed point
// rsp     | out | rsp_tvalid/tready/tdata[7:0]  | char_code in [5:0], tlast on final char
// csr     | in  | csr_we/csr_addr/csr_wdata     | integer_places (0), decimal_places (1)
//
// one value at a time: an accept step, then the integer part shifted bit by bit
// through the bcd cell chain, then one character per cycle (up to 16) while rsp
// is not stalled.
// a stalled rsp holds the character register and pauses the text, not the chain.
// synchronous active-high reset clears control state and the two registers.
// depends on fdac_pkg and fdac_bcd_chain
`default_nettype none

module fixed_to_decimal_ascii_core
   import fdac_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,   // [31:0] value
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [5:0] char_code, [7:6] zero
   output logic                       rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW    = VALUE_W - FRAC_BITS;
   localparam int CNT_W = $clog2(IW + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CONV  = 3'd1;
   localparam logic [2:0] S_SIGN  = 3'd2;
   localparam logic [2:0] S_INT   = 3'd3;
   localparam logic [2:0] S_POINT = 3'd4;
   localparam logic [2:0] S_FRAC  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [IP_W-1:0]      int_places_ff, int_places_in;
   logic [DP_W-1:0]      dec_places_ff, dec_places_in;
   logic                 neg_ff, neg_in;
   logic [IW-1:0]        int_ff, int_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [DP_W-1:0]      dcnt_ff, dcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [IP_W-1:0]      ip_sat;
   logic [DP_W-1:0]      dp_sat;
   logic [31:0]          mag;
   logic [FRAC_BITS+3:0] frac_x10;
   logic [IDX_W-1:0]     sig_count;
   logic [IDX_W-1:0]     icount;
   logic [DSEL_W-1:0]    dsel;
   logic                 out_free;
   logic                 overflow;
   digit_vec_type        digits;
   chain_ctrl_type       chain_ctrl;

   assign ip_sat   = (int_places_ff > IP_W'(INT_DIGITS)) ? IP_W'(INT_DIGITS) : int_places_ff;
   assign dp_sat   = (dec_places_ff > DP_W'(MAX_DEC)) ? DP_W'(MAX_DEC) : dec_places_ff;
   assign mag      = req_tdata[31] ? (32'd0 - req_tdata) : req_tdata;
   assign frac_x10 = {frac_ff, 3'b000} + {2'b00, frac_ff, 1'b0};
   assign icount   = (sig_count > IDX_W'(ip_sat)) ? sig_count : IDX_W'(ip_sat);
   assign dsel     = DSEL_W'(idx_ff - 1'b1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   fdac_bcd_chain u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .ser_in    (int_ff[IW-1]),
      .digits    (digits),
      .sig_count (sig_count),
      .overflow  (overflow)
   );

   always_comb begin
      int_places_in = int_places_ff;
      dec_places_in = dec_places_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_INT_PLACES: int_places_in = csr_wdata[IP_W-1:0];
            REG_DEC_PLACES: dec_places_in = csr_wdata[DP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      int_in       = int_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      chain_ctrl   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               neg_in           = req_tdata[31];
               int_in           = mag[31:FRAC_BITS];
               frac_in          = mag[FRAC_BITS-1:0];
               cnt_in           = CNT_W'(IW);
               dcnt_in          = dp_sat;
               chain_ctrl.clear = 1'b1;
               state_in         = S_CONV;
            end
         end
         S_CONV: begin
            chain_ctrl.shift = 1'b1;
            int_in           = {int_ff[IW-2:0], 1'b0};
            cnt_in           = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = neg_ff ? CH_MINUS : CH_SPACE;
               rsp_last_in  = (icount == '0) && (dp_sat == '0);
               idx_in       = icount;
               priority if (icount != '0) begin
                  state_in = S_INT;
               end else if (dp_sat != '0) begin
                  state_in = S_POINT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_INT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_ZERO + {2'b00, digits[dsel]};
               rsp_last_in  = (idx_ff == IDX_W'(1)) && (dp_sat == '0);
               idx_in       = idx_ff - 1'b1;
               if (idx_ff == IDX_W'(1)) begin
                  state_in = (dp_sat != '0) ? S_POINT : S_IDLE;
               end
            end
         end
         S_POINT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_POINT;
               rsp_last_in  = 1'b0;
               state_in     = S_FRAC;
            end
         end
         S_FRAC: begin
            // next fraction digit is the integer part of ten times the remainder
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_ZERO + {2'b00, frac_x10[FRAC_BITS+3:FRAC_BITS]};
               rsp_last_in  = (dcnt_ff == DP_W'(1));
               frac_in      = frac_x10[FRAC_BITS-1:0];
               dcnt_in      = dcnt_ff - 1'b1;
               if (dcnt_ff == DP_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         int_places_ff <= INT_PLACES_RST;
         dec_places_ff <= DEC_PLACES_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         int_places_ff <= int_places_in;
         dec_places_ff <= dec_places_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      int_ff      <= int_in;
      frac_ff     <= frac_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      dcnt_ff     <= dcnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTH
   // the integer part always fits in the digit chain
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV) |-> !overflow)
      else $error("bcd chain overflow");

   // every character sent is a space, minus, point or decimal digit
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_char_ff == CH_SPACE) || (rsp_char_ff == CH_MINUS) ||
                      (rsp_char_ff == CH_POINT) ||
                      ((rsp_char_ff >= CH_ZERO) && (rsp_char_ff <= CH_NINE))))
      else $error("illegal character code");

   // digit counters stay within their runs
   a_counts: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_INT) |-> ((idx_ff != '0) && (idx_ff <= IDX_W'(INT_DIGITS)))) and
      ((state_ff == S_FRAC) |-> ((dcnt_ff != '0) && (dcnt_ff <= DP_W'(MAX_DEC)))))
      else $error("digit counter out of range");
`endif

endmodule

`default_nettype wire
